[rtl/core/crc8c_pkg.sv]
// Shared types, constants and the CRC-8/MAXIM byte update for the command frame checker.
// No dependencies; every other file in rtl/core refers to this package by scoped names.
package crc8c_pkg;

   localparam int NUM_SLOTS         = 4;
   localparam int SLOT_W            = 2;
   localparam int BYTE_W            = 8;
   localparam int CSR_INDEX_W       = 3;
   localparam int MAX_FRAME_DEFAULT = 255;
   localparam int MIN_FRAME         = 4;
   localparam int PAYLOAD_START     = 2;

   localparam logic [BYTE_W-1:0] CRC_POLY = 8'h8C;

   localparam logic [CSR_INDEX_W-1:0] CSR_SIZE_BASE = 3'd4;

   localparam logic [NUM_SLOTS-1:0][BYTE_W-1:0] CODE_RESET = {8'd10, 8'd9, 8'd8, 8'd7};
   localparam logic [NUM_SLOTS-1:0][BYTE_W-1:0] SIZE_RESET = '0;

   typedef enum logic [2:0] {
      STAT_ACCEPTED     = 3'd0,
      STAT_TOO_LONG     = 3'd1,
      STAT_TOO_SHORT    = 3'd2,
      STAT_CRC_ERROR    = 3'd3,
      STAT_UNKNOWN_CMD  = 3'd4,
      STAT_LEN_MISMATCH = 3'd5
   } status_type;

   typedef logic [NUM_SLOTS-1:0][BYTE_W-1:0] cfg_bank_type;

   typedef struct packed {
      logic [BYTE_W-1:0] payload_byte;
      logic              payload_valid;
      logic [BYTE_W-1:0] payload_offset;
      logic              frame_end;
      status_type        status;
      logic [SLOT_W-1:0] command_slot;
   } result_type;

   function automatic logic [BYTE_W-1:0] crc8_update(input logic [BYTE_W-1:0] crc,
                                                     input logic [BYTE_W-1:0] d);
      logic [BYTE_W-1:0] v;
      v = crc ^ d;
      for (int i = 0; i < BYTE_W; i++) begin
         v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
      end
      return v;
   endfunction

endpackage

[rtl/core/crc8c_frame.sv]
// Frame tracker: CRC accumulator, byte position, latched command and length, and status.
// Depends on crc8c_pkg for the result struct, status codes and the CRC update.
module crc8c_frame #(
   parameter int MAX_FRAME = crc8c_pkg::MAX_FRAME_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             accept,
   input  logic [crc8c_pkg::BYTE_W-1:0]     data_byte,
   input  logic                             last_byte,
   input  crc8c_pkg::cfg_bank_type          code_cfg,
   input  crc8c_pkg::cfg_bank_type          size_cfg,
   output crc8c_pkg::result_type            result
);

   localparam int PW = $clog2(MAX_FRAME + 2);
   localparam int CW = ((PW > 9) ? PW : 9) + 1;
   localparam logic [PW-1:0] POS_LIMIT = PW'(MAX_FRAME + 1);
   localparam logic [PW-1:0] POS_MAX   = PW'(MAX_FRAME);

   logic [crc8c_pkg::BYTE_W-1:0] crc_ff, crc_in;
   logic [PW-1:0]                pos_ff, pos_in;
   logic [crc8c_pkg::BYTE_W-1:0] decl_ff, decl_in;
   logic [crc8c_pkg::SLOT_W-1:0] slot_ff, slot_in;
   logic                         known_ff, known_in;

   logic                         match_known;
   logic [crc8c_pkg::SLOT_W-1:0] match_slot;
   logic                         known_eff;
   logic [crc8c_pkg::SLOT_W-1:0] slot_eff;
   logic [CW-1:0]                pos_ext;
   logic [CW-1:0]                pay_limit;
   logic [CW-1:0]                offset_full;
   logic                         pay_valid;

   always_comb begin
      match_known = 1'b0;
      match_slot  = '0;
      for (int s = crc8c_pkg::NUM_SLOTS - 1; s >= 0; s--) begin
         if (code_cfg[s] == data_byte) begin
            match_known = 1'b1;
            match_slot  = crc8c_pkg::SLOT_W'(s);
         end
      end
   end

   assign known_eff   = (pos_ff == '0) ? match_known : known_ff;
   assign slot_eff    = (pos_ff == '0) ? match_slot : slot_ff;
   assign pos_ext     = CW'(pos_ff);
   assign pay_limit   = CW'(decl_ff) + CW'(crc8c_pkg::PAYLOAD_START);
   assign offset_full = pos_ext - CW'(crc8c_pkg::PAYLOAD_START);
   assign pay_valid   = !last_byte && (pos_ext >= CW'(crc8c_pkg::PAYLOAD_START)) &&
                        (pos_ff < POS_MAX) && (pos_ext < pay_limit);

   always_comb begin
      result.payload_byte   = data_byte;
      result.payload_valid  = pay_valid;
      result.payload_offset = pay_valid ? offset_full[crc8c_pkg::BYTE_W-1:0] : '0;
      result.frame_end      = last_byte;
      result.status         = crc8c_pkg::STAT_ACCEPTED;
      result.command_slot   = '0;
      if (last_byte) begin
         priority if (pos_ff >= POS_MAX) begin
            result.status = crc8c_pkg::STAT_TOO_LONG;
         end else if (pos_ff < PW'(crc8c_pkg::MIN_FRAME - 1)) begin
            result.status = crc8c_pkg::STAT_TOO_SHORT;
         end else if (crc_ff != data_byte) begin
            result.status = crc8c_pkg::STAT_CRC_ERROR;
         end else if (!known_eff) begin
            result.status = crc8c_pkg::STAT_UNKNOWN_CMD;
         end else if (size_cfg[slot_eff] != decl_ff) begin
            result.status = crc8c_pkg::STAT_LEN_MISMATCH;
         end else begin
            result.status = crc8c_pkg::STAT_ACCEPTED;
         end
         result.command_slot = known_eff ? slot_eff : '0;
      end
   end

   always_comb begin
      crc_in   = crc_ff;
      pos_in   = pos_ff;
      decl_in  = decl_ff;
      slot_in  = slot_ff;
      known_in = known_ff;
      if (accept) begin
         if (last_byte) begin
            crc_in   = '0;
            pos_in   = '0;
            decl_in  = '0;
            slot_in  = '0;
            known_in = 1'b0;
         end else begin
            crc_in   = crc8c_pkg::crc8_update(crc_ff, data_byte);
            known_in = known_eff;
            slot_in  = slot_eff;
            if (pos_ff == PW'(1)) begin
               decl_in = data_byte;
            end
            if (pos_ff < POS_LIMIT) begin
               pos_in = pos_ff + PW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff   <= '0;
         pos_ff   <= '0;
         decl_ff  <= '0;
         slot_ff  <= '0;
         known_ff <= 1'b0;
      end else begin
         crc_ff   <= crc_in;
         pos_ff   <= pos_in;
         decl_ff  <= decl_in;
         slot_ff  <= slot_in;
         known_ff <= known_in;
      end
   end

   // The end of a frame returns all frame state to zero.
   a_clear_on_end: assert property (@(posedge clock) disable iff (reset)
      accept && last_byte |=> pos_ff == '0 && crc_ff == '0 && !known_ff)
      else $error("frame state not cleared after the last byte");

   // The position counter never passes its saturation value.
   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_LIMIT)
      else $error("byte position beyond saturation");

   // A non-final byte below saturation advances the position by one.
   a_pos_step: assert property (@(posedge clock) disable iff (reset)
      accept && !last_byte && pos_ff < POS_LIMIT |=> pos_ff == $past(pos_ff) + PW'(1))
      else $error("byte position did not advance");

   // Payload bytes and frame status never appear on the same request.
   a_pay_vs_end: assert property (@(posedge clock) disable iff (reset)
      result.payload_valid |-> !result.frame_end &&
                               result.status == crc8c_pkg::STAT_ACCEPTED)
      else $error("payload byte marked on a frame end");

endmodule

[rtl/core/crc8c_out_stage.sv]
// Output register that holds one result request until the receiver takes it.
// Depends on crc8c_pkg for the result struct.
module crc8c_out_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  crc8c_pkg::result_type load_result,
   input  logic                  take,
   output logic                  out_valid,
   output crc8c_pkg::result_type out_data
);

   logic                  valid_ff, valid_in;
   crc8c_pkg::result_type data_ff, data_in;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = load_result;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

[rtl/core/crc8_command_frame_checker_core.sv]
// Top level of the CRC-8 command frame checker: configuration registers and stream ports.
// Depends on crc8c_pkg, crc8c_frame and crc8c_out_stage.
//
// Each request on the req_ channel carries one received frame byte; req_tlast marks the
// final CRC byte. Each byte yields exactly one request on the rsp_ channel: the echoed
// byte, rsp_tuser set when it lies inside the declared payload, its payload offset, and
// on the frame end (rsp_tlast) a status and the matched command slot.
// The status is accepted only when the frame length is within limits, the CRC-8/MAXIM
// over all bytes before the last equals the last byte, the command byte matches one of
// the four configured codes, and the declared length equals that slot's configured size.
// Each accepted byte's result is registered in the output register. Throughput is one
// byte per cycle while results are taken; the CRC update and status are combinational.
// When the receiver stalls, the output register holds its result and req_tready drops
// until it is taken; a new byte is taken in the same cycle the old result leaves.
// Reset is synchronous: it clears the frame state, empties the output register and loads
// the default command codes 7, 8, 9 and 10 and sizes of zero. The csr_ port writes one
// register per cycle with csr_we high; write it only while no frame is in progress.
module crc8_command_frame_checker_core #(
   parameter int MAX_FRAME = crc8c_pkg::MAX_FRAME_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,  // [7:0] data_byte
   input  logic                              req_tlast,  // last_byte
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [7:0] payload_byte, [15:8] payload_offset, [18:16] status, [20:19] command_slot
   output logic [23:0]                       rsp_tdata,
   output logic                              rsp_tuser,  // payload_valid
   output logic                              rsp_tlast,  // frame_end
   input  logic                              csr_we,
   input  logic [crc8c_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [crc8c_pkg::BYTE_W-1:0]      csr_wdata
);

   crc8c_pkg::cfg_bank_type code_ff, code_in;
   crc8c_pkg::cfg_bank_type size_ff, size_in;
   crc8c_pkg::result_type   frame_result;
   crc8c_pkg::result_type   rsp_result;
   logic                    accept;

   always_comb begin
      code_in = code_ff;
      size_in = size_ff;
      if (csr_we) begin
         if (csr_index < crc8c_pkg::CSR_SIZE_BASE) begin
            code_in[csr_index[crc8c_pkg::SLOT_W-1:0]] = csr_wdata;
         end else begin
            size_in[csr_index[crc8c_pkg::SLOT_W-1:0]] = csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         code_ff <= crc8c_pkg::CODE_RESET;
         size_ff <= crc8c_pkg::SIZE_RESET;
      end else begin
         code_ff <= code_in;
         size_ff <= size_in;
      end
   end

   assign req_tready = !rsp_tvalid || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   crc8c_frame #(
      .MAX_FRAME (MAX_FRAME)
   ) u_frame (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .data_byte (req_tdata),
      .last_byte (req_tlast),
      .code_cfg  (code_ff),
      .size_cfg  (size_ff),
      .result    (frame_result)
   );

   crc8c_out_stage u_out (
      .clock       (clock),
      .reset       (reset),
      .load        (accept),
      .load_result (frame_result),
      .take        (rsp_tready),
      .out_valid   (rsp_tvalid),
      .out_data    (rsp_result)
   );

   assign rsp_tdata = {3'b000, rsp_result.command_slot, rsp_result.status,
                       rsp_result.payload_offset, rsp_result.payload_byte};
   assign rsp_tuser = rsp_result.payload_valid;
   assign rsp_tlast = rsp_result.frame_end;

endmodule

[verif/crc8_frame_checker_monitor.sv]
// Response checker for crc8_command_frame_checker_core. It watches the request, response and
// register ports, predicts every response from its own frame model and compares each field.
// Depends on crc8c_pkg for the status codes and the response record.
module crc8_frame_checker_monitor #(
   parameter int FRAME_LIMIT = crc8c_pkg::MAX_FRAME_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   input  logic [7:0]                        req_tdata,
   input  logic                              req_tlast,
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [23:0]                       rsp_tdata,
   input  logic                              rsp_tuser,
   input  logic                              rsp_tlast,
   input  logic                              csr_we,
   input  logic [crc8c_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]                        csr_wdata,
   output int                                fail_count,
   output int                                pending,
   output int                                results_seen,
   output int                                frames_seen,
   output int                                frames_accepted
);

   logic [7:0] code_reg [crc8c_pkg::NUM_SLOTS];
   logic [7:0] size_reg [crc8c_pkg::NUM_SLOTS];
   logic [7:0] frame_crc;
   int         frame_pos;
   logic [7:0] frame_len;
   logic [1:0] hit_slot;
   logic       hit_known;
   crc8c_pkg::result_type predicted_results [$];

   initial begin
      fail_count      = 0;
      pending         = 0;
      results_seen    = 0;
      frames_seen     = 0;
      frames_accepted = 0;
   end

   function automatic logic [7:0] crc_maxim_next(input logic [7:0] crc, input logic [7:0] d);
      logic [7:0] c;
      logic       fb;
      c = crc;
      for (int i = 0; i < 8; i++) begin
         fb = c[0] ^ d[i];
         c  = c >> 1;
         if (fb) c = c ^ 8'h8C;
      end
      return c;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      fail_count++;
      $display("[%0t] response %0d: %s is %0d, expected %0d",
               $time, results_seen, what, got, want);
   endtask

   task automatic clear_frame();
      frame_crc = '0;
      frame_pos = 0;
      frame_len = '0;
      hit_slot  = '0;
      hit_known = 1'b0;
   endtask

   task automatic model_frame_byte(input logic [7:0] d, input logic fin);
      crc8c_pkg::result_type r;
      int                    span;
      // The lowest slot wins when several codes are equal.
      if (frame_pos == 0) begin
         hit_known = 1'b0;
         hit_slot  = '0;
         for (int s = crc8c_pkg::NUM_SLOTS - 1; s >= 0; s--) begin
            if (code_reg[s] == d) begin
               hit_known = 1'b1;
               hit_slot  = 2'(s);
            end
         end
      end
      r = '0;
      r.payload_byte  = d;
      r.payload_valid = !fin && frame_pos >= crc8c_pkg::PAYLOAD_START &&
                        frame_pos < FRAME_LIMIT &&
                        frame_pos < crc8c_pkg::PAYLOAD_START + int'(frame_len);
      if (r.payload_valid) r.payload_offset = 8'(frame_pos - crc8c_pkg::PAYLOAD_START);
      r.frame_end = fin;
      if (fin) begin
         span = frame_pos + 1;
         if (span > FRAME_LIMIT)                    r.status = crc8c_pkg::STAT_TOO_LONG;
         else if (span < crc8c_pkg::MIN_FRAME)      r.status = crc8c_pkg::STAT_TOO_SHORT;
         else if (frame_crc != d)                   r.status = crc8c_pkg::STAT_CRC_ERROR;
         else if (!hit_known)                       r.status = crc8c_pkg::STAT_UNKNOWN_CMD;
         else if (size_reg[hit_slot] != frame_len)  r.status = crc8c_pkg::STAT_LEN_MISMATCH;
         else                                       r.status = crc8c_pkg::STAT_ACCEPTED;
         if (hit_known) r.command_slot = hit_slot;
         clear_frame();
      end else begin
         if (frame_pos == 1) frame_len = d;
         frame_crc = crc_maxim_next(frame_crc, d);
         if (frame_pos < FRAME_LIMIT + 1) frame_pos++;
      end
      predicted_results.push_back(r);
   endtask

   task automatic check_response();
      crc8c_pkg::result_type want;
      if (predicted_results.size() == 0) begin
         report_mismatch("unrequested response, payload byte", int'(rsp_tdata[7:0]), -1);
      end else begin
         want = predicted_results.pop_front();
         if (rsp_tdata[7:0] !== want.payload_byte)
            report_mismatch("payload byte", int'(rsp_tdata[7:0]), int'(want.payload_byte));
         if (rsp_tuser !== want.payload_valid)
            report_mismatch("payload flag", int'(rsp_tuser), int'(want.payload_valid));
         if (rsp_tdata[15:8] !== want.payload_offset)
            report_mismatch("payload offset", int'(rsp_tdata[15:8]), int'(want.payload_offset));
         if (rsp_tlast !== want.frame_end)
            report_mismatch("frame end", int'(rsp_tlast), int'(want.frame_end));
         if (rsp_tdata[18:16] !== want.status)
            report_mismatch("status", int'(rsp_tdata[18:16]), int'(want.status));
         if (rsp_tdata[20:19] !== want.command_slot)
            report_mismatch("command slot", int'(rsp_tdata[20:19]), int'(want.command_slot));
         if (rsp_tdata[23:21] !== 3'b000)
            report_mismatch("padding bits", int'(rsp_tdata[23:21]), 0);
      end
      results_seen++;
      if (rsp_tlast === 1'b1) begin
         frames_seen++;
         if (rsp_tdata[18:16] === crc8c_pkg::STAT_ACCEPTED) frames_accepted++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < crc8c_pkg::NUM_SLOTS; s++) begin
            code_reg[s] = 8'(s + 7);
            size_reg[s] = '0;
         end
         clear_frame();
         predicted_results.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) check_response();
         if (csr_we) begin
            if (csr_index < crc8c_pkg::CSR_SIZE_BASE) code_reg[2'(csr_index)] = csr_wdata;
            else size_reg[2'(csr_index - crc8c_pkg::CSR_SIZE_BASE)] = csr_wdata;
         end
         if (req_tvalid && req_tready) model_frame_byte(req_tdata, req_tlast);
      end
      pending = predicted_results.size();
   end

endmodule

[verif/tb_crc8_command_frame_checker_core.sv]
// Top testbench for crc8_command_frame_checker_core: drives frames and register settings.
// Depends on crc8c_pkg, the core RTL and crc8_frame_checker_monitor, which does the checking.
module tb_crc8_command_frame_checker_core;

   localparam int         FRAME_LIMIT   = crc8c_pkg::MAX_FRAME_DEFAULT;
   localparam logic [2:0] REG_CODE_BASE = 3'd0;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   logic        csr_we     = 1'b0;
   logic [2:0]  csr_index  = '0;
   logic [7:0]  csr_wdata  = '0;

   int fail_count;
   int pending;
   int results_seen;
   int frames_seen;
   int frames_accepted;

   int         send_idle_pct = 23;
   int         recv_idle_pct = 71;
   int         bytes_sent    = 0;
   logic [7:0] cfg_code [4];
   logic [7:0] cfg_size [4];
   logic [7:0] frame_body [$];

   crc8_command_frame_checker_core #(.MAX_FRAME(FRAME_LIMIT)) uut (.*);

   crc8_frame_checker_monitor #(.FRAME_LIMIT(FRAME_LIMIT)) frame_check (.*);

   always #1 clock = ~clock;

   always @(posedge clock) rsp_tready <= !reset && ($urandom_range(0, 99) >= recv_idle_pct);

   initial begin
      #400000;
      $display("*** FAILED ***");
      $finish;
   end

   task automatic send_byte(input logic [7:0] d, input logic fin);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      req_tlast  <= fin;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic start_frame(input logic [7:0] cmd, input logic [7:0] len);
      frame_body.delete();
      frame_body.push_back(cmd);
      frame_body.push_back(len);
   endtask

   task automatic fill_payload(input int n);
      repeat (n) frame_body.push_back(8'($urandom_range(0, 255)));
   endtask

   task automatic send_frame(input logic corrupt);
      logic [7:0] crc;
      crc = '0;
      foreach (frame_body[i]) crc = crc8c_pkg::crc8_update(crc, frame_body[i]);
      if (corrupt) crc = crc ^ 8'($urandom_range(1, 255));
      foreach (frame_body[i]) send_byte(frame_body[i], 1'b0);
      send_byte(crc, 1'b1);
   endtask

   task automatic random_frame();
      int         kind;
      int         slot;
      logic [7:0] cmd;
      logic [7:0] len;
      kind = $urandom_range(0, 99);
      slot = $urandom_range(0, 3);
      len  = (cfg_size[slot] <= 8'd16) ? cfg_size[slot] : 8'($urandom_range(0, 8));
      if (kind < 70) begin
         // Well-formed frame for a configured command; some carry a bad CRC.
         start_frame(cfg_code[slot], len);
         fill_payload(int'(len));
         send_frame(kind >= 60);
      end else if (kind < 78) begin
         cmd = 8'($urandom_range(0, 255));
         for (int t = 0; t < 4; t++) begin
            if (cmd == cfg_code[0] || cmd == cfg_code[1] || cmd == cfg_code[2] ||
                cmd == cfg_code[3])
               cmd = 8'($urandom_range(0, 255));
         end
         start_frame(cmd, len);
         fill_payload(int'(len));
         send_frame(1'b0);
      end else if (kind < 86) begin
         // Random declared length, often off the configured size; actual length sometimes off both.
         len = 8'($urandom_range(0, 15));
         start_frame(cfg_code[slot], len);
         fill_payload($urandom_range(0, 1) ? int'(len) : int'($urandom_range(0, 15)));
         send_frame(1'b0);
      end else if (kind < 93) begin
         frame_body.delete();
         fill_payload($urandom_range(0, 2));
         send_frame(1'($urandom_range(0, 1)));
      end else begin
         start_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
         fill_payload($urandom_range(0, 10));
         send_frame(1'($urandom_range(0, 1)));
      end
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [7:0] v);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
   endtask

   task automatic apply_setting(input int k);
      logic [7:0] x;
      x = 8'($urandom_range(0, 255));
      for (int s = 0; s < 4; s++) begin
         cfg_code[s] = 8'($urandom_range(0, 255));
         cfg_size[s] = 8'($urandom_range(0, 8));
      end
      unique case (k)
         1: begin
            cfg_code[0] = x;
            cfg_code[2] = x;
         end
         2: begin
            cfg_code[0] = 8'd0;
            cfg_code[1] = 8'd255;
            cfg_code[2] = 8'h80;
            cfg_code[3] = 8'd1;
            cfg_size[0] = 8'd0;
            cfg_size[1] = 8'd252;
            cfg_size[2] = 8'd1;
            cfg_size[3] = 8'd12;
         end
         3: begin
            for (int s = 0; s < 4; s++) cfg_code[s] = 8'd255;
         end
         4: begin
            cfg_size[0] = 8'd252;
            cfg_size[1] = 8'd0;
         end
         default: begin
            for (int s = 0; s < 4; s++) cfg_size[s] = 8'($urandom_range(0, 16));
         end
      endcase
      for (int s = 0; s < 4; s++) write_reg(REG_CODE_BASE + 3'(s), cfg_code[s]);
      for (int s = 0; s < 4; s++) write_reg(crc8c_pkg::CSR_SIZE_BASE + 3'(s), cfg_size[s]);
      csr_we <= 1'b0;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (3) @(posedge clock);
   endtask

   initial begin
      int start_bytes;
      int frames_here;
      int guard;
      for (int s = 0; s < 4; s++) begin
         cfg_code[s] = 8'(s + 7);
         cfg_size[s] = 8'd0;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed frames under the reset codes and sizes: short frames of one to three
      // bytes, then one frame for each of the remaining statuses except too long.
      send_byte(8'hFF, 1'b1);
      send_byte(8'd7, 1'b0);
      send_byte(8'h00, 1'b1);
      send_byte(8'd8, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hA5, 1'b1);
      start_frame(8'd10, 8'd0);
      frame_body.push_back(8'h3C);
      send_frame(1'b0);
      start_frame(8'd7, 8'd0);
      frame_body.push_back(8'h00);
      send_frame(1'b1);
      start_frame(8'd0, 8'd0);
      frame_body.push_back(8'hFF);
      send_frame(1'b0);
      start_frame(8'd8, 8'd1);
      frame_body.push_back(8'h81);
      send_frame(1'b0);

      for (int m = 0; m < 3; m++) begin
         send_idle_pct = (m == 0) ? 23 : (m == 1) ? 71 : 0;
         recv_idle_pct = (m == 0) ? 71 : (m == 1) ? 23 : 0;
         for (int h = 0; h < 2; h++) begin
            drain();
            apply_setting(2 * m + h);
            start_bytes = bytes_sent;
            frames_here = 0;
            if (2 * m + h == 2) begin
               // Longest legal frame, then an overlong one that saturates the position.
               start_frame(8'd255, 8'd252);
               fill_payload(252);
               send_frame(1'b0);
               start_frame(8'd255, 8'd252);
               fill_payload(257);
               send_frame(1'b1);
            end
            while (bytes_sent - start_bytes < 230 || frames_here < 10) begin
               random_frame();
               frames_here++;
            end
         end
      end

      req_tvalid <= 1'b0;
      guard = 0;
      @(negedge clock);
      while (pending != 0 && guard < 20000) begin
         @(negedge clock);
         guard++;
      end
      if (pending != 0) begin
         $display("Timed out with %0d responses outstanding.", pending);
         $display("*** FAILED ***");
         $finish;
      end else begin
         repeat (4) @(posedge clock);
         $display("Sent %0d request bytes under three pacing modes and six register settings.",
                  bytes_sent);
         $display("Checked %0d responses in %0d frames, %0d accepted, %0d mismatches.",
                  results_seen, frames_seen, frames_accepted, fail_count);
         if (fail_count == 0)
            $display("*** PASSED ***");
         else
            $display("*** FAILED ***");
         $finish;
      end
   end

endmodule
